// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the JSON string unescaper.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, character codes and helper functions for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int RUN_FIFO_DEPTH = 4;

    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_U         = 8'h75;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_F         = 8'h66;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CTRL_BS        = 8'h08;
    localparam logic [7:0] CTRL_FF        = 8'h0C;
    localparam logic [7:0] CTRL_LF        = 8'h0A;
    localparam logic [7:0] CTRL_CR        = 8'h0D;
    localparam logic [7:0] CTRL_TAB       = 8'h09;

    localparam logic [7:0]  UTF8_LEAD2      = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3      = 8'hE0;
    localparam logic [7:0]  UTF8_CONT       = 8'h80;
    localparam logic [15:0] CP_ONE_BYTE_LIM = 16'h0080;
    localparam logic [15:0] CP_TWO_BYTE_LIM = 16'h0800;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_BODY  = 3'd1,
        PH_ESC   = 3'd2,
        PH_HEX1  = 3'd3,
        PH_HEX2  = 3'd4,
        PH_HEX3  = 3'd5,
        PH_HEX4  = 3'd6
    } jsu_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } jsu_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic       error;
        logic       last_of_run;
    } jsu_out_t;

    // All results caused by one input byte: up to three bytes, then optionally a done.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nbytes;
        logic            done;
        logic            error;
    } jsu_run_t;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
    } jsu_utf8_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } jsu_hex_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] value;
    } jsu_esc_t;

    function automatic jsu_utf8_t utf8_encode(input logic [15:0] cp);
        jsu_utf8_t r;
        r = '0;
        if (cp < CP_ONE_BYTE_LIM) begin
            r.count    = 2'd1;
            r.bytes[0] = cp[7:0];
        end
        else if (cp < CP_TWO_BYTE_LIM) begin
            r.count    = 2'd2;
            r.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
            r.bytes[1] = UTF8_CONT | {2'b00, cp[5:0]};
        end
        else begin
            r.count    = 2'd3;
            r.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
            r.bytes[1] = UTF8_CONT | {2'b00, cp[11:6]};
            r.bytes[2] = UTF8_CONT | {2'b00, cp[5:0]};
        end
        return r;
    endfunction

    function automatic jsu_hex_t hex_decode(input logic [7:0] b);
        jsu_hex_t r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r.ok    = 1'b1;
            r.value = b[3:0];
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            // Low nibble of 'a'/'A' is 1, so adding nine gives ten.
            r.ok    = 1'b1;
            r.value = b[3:0] + 4'd9;
        end
        return r;
    endfunction

    function automatic jsu_esc_t simple_escape(input logic [7:0] e);
        jsu_esc_t r;
        r.ok = 1'b1;
        unique case (e)
            CHAR_QUOTE:     r.value = CHAR_QUOTE;
            CHAR_BACKSLASH: r.value = CHAR_BACKSLASH;
            CHAR_SLASH:     r.value = CHAR_SLASH;
            CHAR_B:         r.value = CTRL_BS;
            CHAR_F:         r.value = CTRL_FF;
            CHAR_N:         r.value = CTRL_LF;
            CHAR_R:         r.value = CTRL_CR;
            CHAR_T:         r.value = CTRL_TAB;
            default:
            begin
                r.ok    = 1'b0;
                r.value = 8'h00;
            end
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/json_string_unescape_top.sv
// A taken input's run is written into the run queue, then walked into the output register.
// Throughput: one input byte per cycle while each byte gives at most one result
// and result_stall is low; a \u escape that yields several bytes holds the output
// sequencer per result, and the RUN_DEPTH-entry run queue absorbs that expansion.
// Reset (rst_n, asynchronous): decoder state, run queue and output valid clear at
// once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// json_string_unescape_top
// JSON string unescaper with UTF-8 output for \u escapes.
// ----------------------------------------------------------------------------
module json_string_unescape_top
#(
    parameter int RUN_DEPTH = jsu_pkg::RUN_FIFO_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  jsu_pkg::jsu_in_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output jsu_pkg::jsu_out_t result
);

    logic              accept;
    logic              push;
    logic              pop;
    logic              empty;
    logic              full;
    jsu_pkg::jsu_run_t push_run;
    jsu_pkg::jsu_run_t head;

    // The front may only advance when the queue has room for the run it builds.
    assign item_stall = full;
    assign accept     = item_valid && !full;

    jsu_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push),
        .run    (push_run)
    );

    jsu_run_fifo #(.DEPTH(RUN_DEPTH)) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    jsu_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: hw/rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Decodes one raw byte per transaction and builds the run of results it causes.
// ----------------------------------------------------------------------------
module jsu_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  jsu_pkg::jsu_in_t item,
    output logic             push,
    output jsu_pkg::jsu_run_t run
);

    jsu_pkg::jsu_phase_t phase_reg, phase_next;
    logic [15:0]         code_point_reg, code_point_next;
    logic                error_reg, error_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= jsu_pkg::PH_START;
            code_point_reg <= '0;
            error_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            code_point_reg <= code_point_next;
            error_reg      <= error_next;
        end
    end

    always_comb
    begin
        logic [7:0]         b;
        logic [15:0]        shifted;
        jsu_pkg::jsu_hex_t  hex;
        jsu_pkg::jsu_esc_t  esc;
        jsu_pkg::jsu_utf8_t enc;

        b       = item.data_byte;
        shifted = {code_point_reg[11:0], 4'h0};
        hex     = jsu_pkg::hex_decode(b);
        esc     = jsu_pkg::simple_escape(b);
        enc     = '0;

        phase_next      = phase_reg;
        code_point_next = code_point_reg;
        error_next      = error_reg;
        run             = '0;

        unique case (phase_reg)
            jsu_pkg::PH_BODY:
            begin
                if (b == jsu_pkg::CHAR_QUOTE)
                begin
                    run.done = 1'b1;
                end
                else if (b == jsu_pkg::CHAR_BACKSLASH)
                begin
                    phase_next = jsu_pkg::PH_ESC;
                end
                else
                begin
                    run.bytes[0] = b;
                    run.nbytes   = 2'd1;
                end
            end
            jsu_pkg::PH_ESC:
            begin
                phase_next = jsu_pkg::PH_BODY;
                if (b == jsu_pkg::CHAR_U)
                begin
                    code_point_next = '0;
                    phase_next      = jsu_pkg::PH_HEX1;
                end
                else if (esc.ok)
                begin
                    run.bytes[0] = esc.value;
                    run.nbytes   = 2'd1;
                end
                else
                begin
                    error_next = 1'b1;
                end
            end
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3, jsu_pkg::PH_HEX4:
            begin
                if (!hex.ok)
                begin
                    // The partial code point is still emitted after a bad digit.
                    error_next      = 1'b1;
                    code_point_next = shifted;
                    enc             = jsu_pkg::utf8_encode(shifted);
                    run.bytes       = enc.bytes;
                    run.nbytes      = enc.count;
                    phase_next      = jsu_pkg::PH_BODY;
                end
                else
                begin
                    code_point_next = shifted | {12'h000, hex.value};
                    unique case (phase_reg)
                        jsu_pkg::PH_HEX1: phase_next = jsu_pkg::PH_HEX2;
                        jsu_pkg::PH_HEX2: phase_next = jsu_pkg::PH_HEX3;
                        jsu_pkg::PH_HEX3: phase_next = jsu_pkg::PH_HEX4;
                        default:
                        begin
                            enc        = jsu_pkg::utf8_encode(shifted | {12'h000, hex.value});
                            run.bytes  = enc.bytes;
                            run.nbytes = enc.count;
                            phase_next = jsu_pkg::PH_BODY;
                        end
                    endcase
                end
            end
            default:
            begin
                // Opening quote: taken unchecked, starts a new string.
                error_next      = 1'b0;
                code_point_next = '0;
                phase_next      = jsu_pkg::PH_BODY;
            end
        endcase

        if (item.end_of_input && !run.done)
        begin
            error_next = 1'b1;
            run.done   = 1'b1;
        end
        if (run.done)
        begin
            phase_next = jsu_pkg::PH_START;
        end
        run.error = error_next;
    end

    assign push = accept && ((run.nbytes != 2'd0) || run.done);

endmodule

// File: hw/rtl/jsu_run_fifo.sv
// ----------------------------------------------------------------------------
// jsu_run_fifo
// Short queue of result runs between the decoder and the output sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_run_fifo
#(
    parameter int DEPTH = jsu_pkg::RUN_FIFO_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jsu_pkg::jsu_run_t push_run,
    input  logic              pop,
    output jsu_pkg::jsu_run_t head,
    output logic              empty,
    output logic              full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::jsu_run_t mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));

    `ASSERT_IMPLY(a_no_push_when_full, clk, rst_n, push, !full || pop)
    `ASSERT_IMPLY(a_no_pop_when_empty, clk, rst_n, pop, !empty)

endmodule

// File: hw/rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Walks the head run one result per cycle into the output register unless result_stall holds it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  jsu_pkg::jsu_run_t head,
    input  logic              empty,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output jsu_pkg::jsu_out_t result
);

    logic              out_valid_reg, out_valid_next;
    jsu_pkg::jsu_out_t out_reg, out_next;
    logic [1:0]        idx_reg, idx_next;
    logic              load;
    logic [2:0]        total;
    logic              last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign load  = !out_valid_reg || !result_stall;
    assign total = {1'b0, head.nbytes} + {2'b00, head.done};
    assign last  = ({1'b0, idx_reg} == (total - 3'd1));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        idx_next       = idx_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = !empty;
            if (!empty)
            begin
                if (idx_reg < head.nbytes)
                begin
                    out_next.out_byte    = head.bytes[idx_reg];
                    out_next.byte_valid  = 1'b1;
                    out_next.string_done = 1'b0;
                end
                else
                begin
                    out_next.out_byte    = 8'h00;
                    out_next.byte_valid  = 1'b0;
                    out_next.string_done = 1'b1;
                end
                out_next.error       = head.error;
                out_next.last_of_run = last;
                if (last)
                begin
                    pop      = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `ASSERT_IMPLY(a_head_run_not_empty, clk, rst_n, !empty, total != 3'd0)
    `ASSERT_IMPLY(a_index_in_run, clk, rst_n, !empty, {1'b0, idx_reg} < total)

endmodule
